>>> rtl/core/lfrr_pkg.sv
// shared types, constants and defaults of the length framed receiver with frame ring
package lfrr_pkg;

  // default sizes handed to the top level parameters
  localparam int RING_SLOTS_DEF  = 4;
  localparam int FRAME_BYTES_DEF = 64;

  // field widths fixed by the item format
  localparam int BYTE_W     = 8;
  localparam int OVH_W      = 7;
  localparam int SUM_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int HDR_BYTES  = 4;
  localparam int HDR_IDX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAD   = 2'd2;

  // configuration reset values
  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h55;
  localparam logic [OVH_W-1:0]  OVERHEAD_RST   = 7'd6;

  // input item kinds
  localparam logic ACT_RECEIVE = 1'b0;
  localparam logic ACT_TAKE    = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SEND
  } ctrl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic rx_en;
    logic take_start;
    logic fetch;
    logic next_byte;
    logic finish;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic ring_empty;
    logic send_last;
  } dp_sts_t;

endpackage

>>> rtl/core/length_framed_rx_ring_core.sv
// top level of the length framed receiver with a ring of completed frames
// Usage: received bytes and take requests enter on the in_ stream channel. in_tuser
// selects the item kind: 0 delivers the byte in in_tdata, 1 asks for the oldest
// stored frame. A receive item gives no result, and the block stays ready for the
// next item. A take item gives one result per frame byte on the out_ channel, with
// out_tlast on the final byte and the frame length beside every byte; an empty ring
// gives one result with out_tuser low and out_tlast high. Each frame byte is first
// read from the ring memory with a registered read in the fetch state and then held
// in the send state; an empty take goes straight to the send state. While results
// are pending in_tready is low; a stall on out_tready simply holds the current
// result and the block waits. Configuration writes on the cfg_ channel are always
// ready and take effect at the next cycle. Reset clears the frame state and the ring
// pointers and restores the register defaults; memory contents are left as they are
// and are never read before being written.
module length_framed_rx_ring_core #(
  parameter int RING_SLOTS  = lfrr_pkg::RING_SLOTS_DEF,
  parameter int FRAME_BYTES = lfrr_pkg::FRAME_BYTES_DEF,
  parameter int LEN_W       = $clog2(FRAME_BYTES + 1),
  parameter int OUT_DATA_W  = ((lfrr_pkg::BYTE_W + LEN_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input item channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lfrr_pkg::BYTE_W-1:0]    in_tdata,   // [7:0] rx_byte
  input  logic                           in_tuser,   // [0] action
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_DATA_W-1:0]          out_tdata,  // [7:0] frame_byte, then frame_length
  output logic                           out_tuser,  // [0] frame_present
  output logic                           out_tlast,  // last_byte
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lfrr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lfrr_pkg::BYTE_W-1:0]    cfg_data
);

  lfrr_pkg::dp_cmd_t            cmd;
  lfrr_pkg::dp_sts_t            sts;
  logic [lfrr_pkg::BYTE_W-1:0]  frame_byte;
  logic [LEN_W-1:0]             frame_length;

  // configuration is accepted every cycle
  assign cfg_ready = 1'b1;

  lfrr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_action  (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  lfrr_dp #(
    .RING_SLOTS  (RING_SLOTS),
    .FRAME_BYTES (FRAME_BYTES),
    .LEN_W       (LEN_W)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rx_byte       (in_tdata),
    .cmd           (cmd),
    .sts           (sts),
    .frame_present (out_tuser),
    .frame_byte    (frame_byte),
    .frame_length  (frame_length),
    .last_byte     (out_tlast)
  );

  // result packing, zero padded to whole bytes
  assign out_tdata = OUT_DATA_W'({frame_length, frame_byte});

`ifndef SYNTHESIS
  // input and result sides are never open together
  a_excl_sides: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  // a take on an empty ring answers next cycle with a single no-frame result
  a_empty_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == lfrr_pkg::ACT_TAKE) && sts.ring_empty)
    |=> (out_tvalid && !out_tuser && out_tlast))
    else $error("empty take did not give a single no-frame result");

  // a non-final frame byte is followed by a fetch state and then the next byte
  a_fetch_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> (!out_tvalid ##1 out_tvalid))
    else $error("frame byte sequence broke off");
`endif

endmodule

>>> rtl/core/lfrr_ctrl.sv
// controller state machine: input acceptance, byte fetch and result handshake
module lfrr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_action,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  lfrr_pkg::dp_sts_t sts,
  output lfrr_pkg::dp_cmd_t cmd
);

  lfrr_pkg::ctrl_state_t state_r, state_nxt;
  logic in_fire;
  logic out_fire;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfrr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lfrr_pkg::ST_IDLE: begin
        if (in_fire && (in_action == lfrr_pkg::ACT_TAKE)) begin
          state_nxt = sts.ring_empty ? lfrr_pkg::ST_SEND : lfrr_pkg::ST_FETCH;
        end
      end
      lfrr_pkg::ST_FETCH: begin
        state_nxt = lfrr_pkg::ST_SEND;
      end
      lfrr_pkg::ST_SEND: begin
        if (out_fire) begin
          state_nxt = sts.send_last ? lfrr_pkg::ST_IDLE : lfrr_pkg::ST_FETCH;
        end
      end
      default: begin
        state_nxt = lfrr_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    in_tready      = 1'b0;
    out_tvalid     = 1'b0;
    cmd            = '0;
    unique case (state_r)
      lfrr_pkg::ST_IDLE: begin
        in_tready      = 1'b1;
        cmd.rx_en      = in_fire && (in_action == lfrr_pkg::ACT_RECEIVE);
        cmd.take_start = in_fire && (in_action == lfrr_pkg::ACT_TAKE);
      end
      lfrr_pkg::ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      lfrr_pkg::ST_SEND: begin
        out_tvalid     = 1'b1;
        cmd.next_byte  = out_fire && !sts.send_last;
        cmd.finish     = out_fire && sts.send_last;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/core/lfrr_dp.sv
// datapath: configuration registers, frame assembly, ring memory and take readout
module lfrr_dp #(
  parameter int RING_SLOTS  = lfrr_pkg::RING_SLOTS_DEF,
  parameter int FRAME_BYTES = lfrr_pkg::FRAME_BYTES_DEF,
  parameter int LEN_W       = $clog2(FRAME_BYTES + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lfrr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lfrr_pkg::BYTE_W-1:0]    cfg_data,
  input  logic [lfrr_pkg::BYTE_W-1:0]    rx_byte,
  input  lfrr_pkg::dp_cmd_t              cmd,
  output lfrr_pkg::dp_sts_t              sts,
  output logic                           frame_present,
  output logic [lfrr_pkg::BYTE_W-1:0]    frame_byte,
  output logic [LEN_W-1:0]               frame_length,
  output logic                           last_byte
);

  localparam int SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int IDX_W  = $clog2(FRAME_BYTES);
  localparam int DEPTH  = RING_SLOTS * FRAME_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_SLOTS - 1);

  // configuration registers
  logic [lfrr_pkg::BYTE_W-1:0] start_byte_r;
  logic [lfrr_pkg::BYTE_W-1:0] end_byte_r;
  logic [lfrr_pkg::OVH_W-1:0]  overhead_r;

  // assembly control
  logic                         in_frame_r;
  logic [LEN_W-1:0]             count_r;
  logic [LEN_W-1:0]             exp_r;
  logic [lfrr_pkg::BYTE_W-1:0]  hdr_r [lfrr_pkg::HDR_BYTES];
  logic [SLOT_W-1:0]            ws_r;
  logic [SLOT_W-1:0]            rs_r;
  logic [LEN_W-1:0]             len_r [RING_SLOTS];

  // ring memory and readout
  logic [lfrr_pkg::BYTE_W-1:0]  ring_mem [DEPTH];
  logic [lfrr_pkg::BYTE_W-1:0]  rdata_r;
  logic [IDX_W-1:0]             rd_idx_r;
  logic                         present_r;

  // receive decode
  logic                         open_frame;
  logic                         abandon_full;
  logic                         take_byte;
  logic [LEN_W-1:0]             cnt_n;
  logic [lfrr_pkg::SUM_W-1:0]   total_sum;
  logic                         at_len;
  logic                         closing;
  logic [lfrr_pkg::HDR_IDX_W-1:0] end_idx;
  logic [lfrr_pkg::BYTE_W-1:0]  end_sel;
  logic                         store;
  logic [SLOT_W-1:0]            ws_inc;
  logic [SLOT_W-1:0]            rs_inc;
  logic                         mem_we;
  logic [IDX_W-1:0]             wr_idx;
  logic [ADDR_W-1:0]            wr_addr;
  logic [ADDR_W-1:0]            rd_addr;
  logic [LEN_W-1:0]             cur_len;

  // slot increments with wrap
  assign ws_inc = (ws_r == LAST_SLOT) ? '0 : SLOT_W'(ws_r + 1'b1);
  assign rs_inc = (rs_r == LAST_SLOT) ? '0 : SLOT_W'(rs_r + 1'b1);

  // receive path decode
  assign open_frame   = cmd.rx_en && !in_frame_r && (rx_byte == start_byte_r);
  assign abandon_full = cmd.rx_en && in_frame_r && (count_r >= LEN_W'(FRAME_BYTES));
  assign take_byte    = cmd.rx_en && in_frame_r && !(count_r >= LEN_W'(FRAME_BYTES));
  assign cnt_n        = LEN_W'(count_r + 1'b1);
  assign total_sum    = lfrr_pkg::SUM_W'(overhead_r)
                      + lfrr_pkg::SUM_W'({rx_byte, hdr_r[2]});
  assign at_len       = (cnt_n == LEN_W'(lfrr_pkg::HDR_BYTES));
  assign closing      = take_byte && !at_len && (exp_r != '0) && (cnt_n >= exp_r);
  assign end_idx      = lfrr_pkg::HDR_IDX_W'(exp_r - 1'b1);
  assign end_sel      = (exp_r == cnt_n) ? rx_byte : hdr_r[end_idx];
  assign store        = closing && (end_sel == end_byte_r);

  // memory addressing: the free slot at ws_r doubles as the assembly buffer
  assign mem_we  = open_frame || take_byte;
  assign wr_idx  = open_frame ? '0 : count_r[IDX_W-1:0];
  assign wr_addr = ADDR_W'(ADDR_W'(ws_r) * ADDR_W'(FRAME_BYTES) + ADDR_W'(wr_idx));
  assign rd_addr = ADDR_W'(ADDR_W'(rs_r) * ADDR_W'(FRAME_BYTES) + ADDR_W'(rd_idx_r));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= lfrr_pkg::START_BYTE_RST;
      end_byte_r   <= lfrr_pkg::END_BYTE_RST;
      overhead_r   <= lfrr_pkg::OVERHEAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lfrr_pkg::CFG_START_BYTE: start_byte_r <= cfg_data;
        lfrr_pkg::CFG_END_BYTE:   end_byte_r   <= cfg_data;
        lfrr_pkg::CFG_OVERHEAD:   overhead_r   <= cfg_data[lfrr_pkg::OVH_W-1:0];
        default: begin
          start_byte_r <= start_byte_r;
        end
      endcase
    end
  end

  // frame assembly control and slot pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      count_r    <= '0;
      exp_r      <= '0;
      ws_r       <= '0;
      rs_r       <= '0;
    end else begin
      if (open_frame) begin
        in_frame_r <= 1'b1;
        exp_r      <= '0;
        count_r    <= LEN_W'(1);
      end else if (abandon_full) begin
        in_frame_r <= 1'b0;
      end else if (take_byte) begin
        count_r <= cnt_n;
        if (at_len) begin
          exp_r <= LEN_W'(total_sum);
          if (total_sum > lfrr_pkg::SUM_W'(FRAME_BYTES)) begin
            in_frame_r <= 1'b0;
          end
        end else if (closing) begin
          in_frame_r <= 1'b0;
        end
      end
      // commit a good frame, dropping the oldest when the ring fills
      if (store) begin
        ws_r <= ws_inc;
        if (ws_inc == rs_r) begin
          rs_r <= rs_inc;
        end
      end else if (cmd.finish && present_r) begin
        rs_r <= rs_inc;
      end
    end
  end

  // header byte copies and stored frame lengths
  always_ff @(posedge clk) begin
    if (open_frame) begin
      hdr_r[0] <= rx_byte;
    end else if (take_byte && (count_r < LEN_W'(lfrr_pkg::HDR_BYTES))) begin
      hdr_r[count_r[lfrr_pkg::HDR_IDX_W-1:0]] <= rx_byte;
    end
    if (store) begin
      len_r[ws_r] <= cnt_n;
    end
  end

  // ring memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[wr_addr] <= rx_byte;
    end
    if (cmd.fetch) begin
      rdata_r <= ring_mem[rd_addr];
    end
  end

  // take readout position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= 1'b0;
      rd_idx_r  <= '0;
    end else if (cmd.take_start) begin
      present_r <= (rs_r != ws_r);
      rd_idx_r  <= '0;
    end else if (cmd.next_byte) begin
      rd_idx_r <= IDX_W'(rd_idx_r + 1'b1);
    end
  end

  // result fields
  assign cur_len       = len_r[rs_r];
  assign frame_present = present_r;
  assign frame_byte    = present_r ? rdata_r : '0;
  assign frame_length  = present_r ? cur_len : '0;
  assign last_byte     = present_r ? ((LEN_W'(rd_idx_r) + LEN_W'(1)) == cur_len) : 1'b1;

  // status to the controller
  assign sts.ring_empty = (rs_r == ws_r);
  assign sts.send_last  = last_byte;

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the length framed receiver with its ring of stored frames
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lfrr_pkg::*;

  localparam int RING        = RING_SLOTS_DEF;
  localparam int FB          = FRAME_BYTES_DEF;
  localparam int LEN_BITS    = $clog2(FB + 1);
  localparam int OUT_W       = ((BYTE_W + LEN_BITS + 7) / 8) * 8;
  localparam int LIMIT       = 300000;
  localparam int HOLD_CYCLES = 250;
  localparam int SETTLE      = 10;

  // one input item: kind and received byte
  typedef struct packed {
    logic              act;
    logic [BYTE_W-1:0] data;
  } rx_item_t;

  // one result of a take request
  typedef struct packed {
    logic                present;
    logic [BYTE_W-1:0]   fbyte;
    logic [LEN_BITS-1:0] flen;
    logic                last;
  } taken_byte_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [BYTE_W-1:0]    in_tdata   = '0;
  logic                 in_tuser   = ACT_RECEIVE;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = CFG_START_BYTE;
  logic [BYTE_W-1:0]    cfg_data   = '0;

  length_framed_rx_ring_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus and expected results
  rx_item_t    rx_items_q[$];
  taken_byte_t taken_bytes_q[$];
  int          items_left = 0;
  int          mism_cnt   = 0;
  int          cycles     = 0;
  logic        quiet      = 1'b0;
  logic        hold_req   = 1'b0;

  // shadow of the configuration registers
  logic [BYTE_W-1:0] start_sh = START_BYTE_RST;
  logic [BYTE_W-1:0] end_sh   = END_BYTE_RST;
  logic [OVH_W-1:0]  ovh_sh   = OVERHEAD_RST;

  // shadow of the frame assembly and the ring
  logic              in_frame_sh = 1'b0;
  logic [BYTE_W-1:0] asm_sh[FB];
  int                asm_cnt     = 0;
  int                total_sh    = 0;
  logic [BYTE_W-1:0] ring_sh[RING][FB];
  int                ring_len_sh[RING];
  int                wr_sh       = 0;
  int                rd_sh       = 0;

  // copy a completed frame into the ring, dropping the oldest when full
  function automatic void store_frame();
    for (int i = 0; i < asm_cnt; i++) ring_sh[wr_sh][i] = asm_sh[i];
    ring_len_sh[wr_sh] = asm_cnt;
    wr_sh = (wr_sh + 1) % RING;
    if (wr_sh == rd_sh) rd_sh = (rd_sh + 1) % RING;
  endfunction

  // frame assembly for one received byte
  function automatic void predict_rx(logic [BYTE_W-1:0] b);
    if (!in_frame_sh) begin
      if (b == start_sh) begin
        in_frame_sh = 1'b1;
        total_sh    = 0;
        asm_sh[0]   = b;
        asm_cnt     = 1;
      end
      return;
    end
    if (asm_cnt >= FB) begin
      in_frame_sh = 1'b0;
      return;
    end
    asm_sh[asm_cnt] = b;
    asm_cnt++;
    if (asm_cnt == HDR_BYTES) begin
      // little-endian payload length sits in bytes 2 and 3
      total_sh = int'(ovh_sh) + int'({asm_sh[3], asm_sh[2]});
      if (total_sh > FB) in_frame_sh = 1'b0;
    end else if (total_sh > 0 && asm_cnt >= total_sh) begin
      if (asm_sh[total_sh-1] == end_sh) store_frame();
      in_frame_sh = 1'b0;
    end
  endfunction

  // results of a take request: the oldest frame byte by byte, or one empty marker
  function automatic void predict_take();
    int n;
    if (rd_sh == wr_sh) begin
      taken_bytes_q.push_back('{present: 1'b0, fbyte: '0, flen: '0, last: 1'b1});
      return;
    end
    n = ring_len_sh[rd_sh];
    for (int i = 0; i < n; i++)
      taken_bytes_q.push_back('{present: 1'b1, fbyte: ring_sh[rd_sh][i],
                                flen: LEN_BITS'(n), last: (i == n - 1)});
    rd_sh = (rd_sh + 1) % RING;
  endfunction

  // compare one accepted result with the oldest expectation
  function automatic void check_result();
    taken_byte_t want;
    if (taken_bytes_q.size() == 0) begin
      mism_cnt++;
      if (mism_cnt <= 10)
        $display("%0t: unexpected result tdata %h tuser %b tlast %b",
                 $realtime, out_tdata, out_tuser, out_tlast);
      return;
    end
    want = taken_bytes_q.pop_front();
    if (out_tuser !== want.present || out_tdata[BYTE_W-1:0] !== want.fbyte ||
        out_tdata[BYTE_W +: LEN_BITS] !== want.flen || out_tlast !== want.last) begin
      mism_cnt++;
      if (mism_cnt <= 10)
        $display("%0t: mismatch exp present %b byte %h len %0d last %b, got %b %h %0d %b",
                 $realtime, want.present, want.fbyte, want.flen, want.last, out_tuser,
                 out_tdata[BYTE_W-1:0], out_tdata[BYTE_W +: LEN_BITS], out_tlast);
    end
  endfunction

  // driver: offers queued items, with random gaps outside the quiet tail
  int       gap_left = 0;
  rx_item_t drv_item;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (in_tuser == ACT_TAKE) predict_take();
        else predict_rx(in_tdata);
        items_left--;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (rx_items_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 3);
          in_tvalid <= 1'b0;
        end else begin
          drv_item = rx_items_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= drv_item.act;
          in_tdata  <= drv_item.data;
        end
      end
    end
  end

  // long receiver hold-off, counted in cycles on its own
  logic hold_seen = 1'b0;
  logic hold_on   = 1'b0;
  int   hold_left = 0;
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      hold_on   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      hold_on   <= (hold_left > 1);
    end
  end

  // monitor: checks results and drives out_tready, with short stalls
  int   stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_result();
      if (hold_on) begin
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void push_rx(logic [BYTE_W-1:0] b);
    rx_items_q.push_back('{act: ACT_RECEIVE, data: b});
    items_left++;
  endfunction

  // take request, with a random byte riding along that the block ignores
  function automatic void push_take();
    rx_items_q.push_back('{act: ACT_TAKE, data: BYTE_W'($urandom)});
    items_left++;
  endfunction

  // byte outside a frame that must not open one
  function automatic void push_noise();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom);
    if (b == start_sh) b = ~b;
    push_rx(b);
  endfunction

  // frame with the given payload length; an overlong one stops after its header
  function automatic int push_frame(int plen, bit good_end);
    int total;
    logic [BYTE_W-1:0] b;
    total = int'(ovh_sh) + plen;
    push_rx(start_sh);
    push_rx(BYTE_W'($urandom));
    push_rx(plen[7:0]);
    push_rx(plen[15:8]);
    if (total > FB) return HDR_BYTES;
    for (int i = HDR_BYTES; i < total - 1; i++) push_rx(BYTE_W'($urandom));
    b = good_end ? end_sh : end_sh ^ BYTE_W'($urandom_range(1, 255));
    push_rx(b);
    return total;
  endfunction

  // payload length that fits, mostly short
  function automatic int pick_plen();
    int max_plen;
    max_plen = FB - int'(ovh_sh);
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, max_plen);
    return $urandom_range(0, (max_plen < 4) ? max_plen : 4);
  endfunction

  // random mix of frames, broken frames, takes, noise and ring-filling bursts
  function automatic void run_random(int n_items);
    int cnt;
    int k;
    cnt = 0;
    while (cnt < n_items) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        cnt += push_frame(pick_plen(), 1'b1);
      end else if (k < 55) begin
        cnt += push_frame(pick_plen(), 1'b0);
      end else if (k < 62) begin
        cnt += push_frame($urandom_range(FB + 1 - int'(ovh_sh), 65535), 1'b1);
      end else if (k < 88) begin
        push_take();
        cnt++;
      end else if (k < 94) begin
        repeat ($urandom_range(1, 3)) push_noise();
      end else begin
        // overfill the ring, then drain it and ask once more
        repeat (RING) cnt += push_frame(0, 1'b1);
        repeat (RING) push_take();
        cnt += RING;
      end
    end
  endfunction

  // wait until every item is taken and every result has come, then let the block settle
  task automatic drain();
    @(posedge clk);
    while (items_left != 0 || taken_bytes_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write on the configuration channel
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_START_BYTE: start_sh = val;
      CFG_END_BYTE:   end_sh   = val;
      CFG_OVERHEAD:   ovh_sh   = val[OVH_W-1:0];
      default: ;
    endcase
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty take, ignored bytes, good, bad-ended and overlong frames
    push_take();
    push_rx(8'h00);
    push_rx(8'hFF);
    void'(push_frame(0, 1'b1));
    void'(push_frame(0, 1'b0));
    void'(push_frame(16'hFFFF, 1'b1));
    push_take();
    push_take();
    run_random(12);
    drain();

    // smallest overhead, extreme bytes; receiver holds off while takes pile up
    write_reg(CFG_START_BYTE, 8'h00);
    write_reg(CFG_END_BYTE, 8'hFF);
    write_reg(CFG_OVERHEAD, 8'd5);
    hold_req <= ~hold_req;
    void'(push_frame(0, 1'b1));
    void'(push_frame(1, 1'b1));
    push_take();
    push_take();
    run_random(8);
    drain();

    // largest overhead: every good frame fills the assembly buffer
    write_reg(CFG_START_BYTE, 8'hFF);
    write_reg(CFG_END_BYTE, 8'h00);
    write_reg(CFG_OVERHEAD, 8'd64);
    void'(push_frame(0, 1'b1));
    push_take();
    drain();

    // random settings, then a tail with no idling on either side
    write_reg(CFG_START_BYTE, BYTE_W'($urandom));
    write_reg(CFG_END_BYTE, BYTE_W'($urandom));
    write_reg(CFG_OVERHEAD, BYTE_W'($urandom_range(5, 12)));
    run_random(6);
    drain();
    quiet <= 1'b1;
    run_random(6);
    drain();
    repeat (SETTLE) @(posedge clk);

    if (mism_cnt == 0 && taken_bytes_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/lfrr_pkg.sv
rtl/core/lfrr_ctrl.sv
rtl/core/lfrr_dp.sv
rtl/core/length_framed_rx_ring_core.sv
tb/tb_top.sv
